FILE: rtl/spc_pkg.sv
`default_nettype none
package spc_pkg;

    localparam int CW         = 32;   // coordinate
    localparam int RW         = 31;   // radius / detect distance
    localparam int DW         = 33;   // center difference magnitude
    localparam int SW         = 66;   // sum of squares
    localparam int LW         = 34;   // length (root)
    localparam int PW         = 64;   // radius * magnitude
    localparam int NW         = 65;   // rounded numerator
    localparam int QW         = 31;   // offset quotient
    localparam int GW         = 33;   // gap
    localparam int SQ_STAGES  = 34;
    localparam int DIV_STAGES = 31;
    // diff, multiply, sum, root, numerator, divide, output
    localparam int LAT        = 3 + SQ_STAGES + 1 + DIV_STAGES + 1;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic        [RW-1:0] t_rad;
    typedef logic signed [GW-1:0] t_gap;

    typedef struct packed {
        t_coord [2:0]          a;
        t_coord [2:0]          b;
        t_rad                  ra;
        t_rad                  rb;
        logic   [2:0]          neg;
        logic   [2:0][PW-1:0]  pa;
        logic   [2:0][PW-1:0]  pb;
    } t_side;

    typedef struct packed {
        t_coord [2:0] a;
        t_coord [2:0] b;
        logic   [2:0] neg;
        logic         lzero;
        t_gap         gap;
    } t_tail;

    function automatic t_coord sat32(input logic signed [CW+1:0] v);
        if (v > $signed({3'b000, {(CW-1){1'b1}}}))
            return {1'b0, {(CW-1){1'b1}}};
        else if (v < $signed({3'b111, {(CW-1){1'b0}}}))
            return {1'b1, {(CW-1){1'b0}}};
        else
            return v[CW-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/spc_pair_if.sv
`default_nettype none
interface spc_pair_if;
    logic           valid;
    logic           ready;
    spc_pkg::t_coord center_a_x;
    spc_pkg::t_coord center_a_y;
    spc_pkg::t_coord center_a_z;
    spc_pkg::t_rad   radius_a;
    spc_pkg::t_coord center_b_x;
    spc_pkg::t_coord center_b_y;
    spc_pkg::t_coord center_b_z;
    spc_pkg::t_rad   radius_b;

    modport source (output valid, center_a_x, center_a_y, center_a_z, radius_a,
                    center_b_x, center_b_y, center_b_z, radius_b, input ready);
    modport sink   (input valid, center_a_x, center_a_y, center_a_z, radius_a,
                    center_b_x, center_b_y, center_b_z, radius_b, output ready);
endinterface
`default_nettype wire

FILE: rtl/spc_contact_if.sv
`default_nettype none
interface spc_contact_if;
    logic            valid;
    logic            ready;
    spc_pkg::t_coord touch_a_x;
    spc_pkg::t_coord touch_a_y;
    spc_pkg::t_coord touch_a_z;
    spc_pkg::t_coord touch_b_x;
    spc_pkg::t_coord touch_b_y;
    spc_pkg::t_coord touch_b_z;
    spc_pkg::t_gap   gap;

    modport source (output valid, touch_a_x, touch_a_y, touch_a_z, touch_b_x,
                    touch_b_y, touch_b_z, gap, input ready);
    modport sink   (input valid, touch_a_x, touch_a_y, touch_a_z, touch_b_x,
                    touch_b_y, touch_b_z, gap, output ready);
endinterface
`default_nettype wire

FILE: rtl/spc_sqrt.sv
`default_nettype none
// Pipelined digit-by-digit square root, one result bit per stage.
module spc_sqrt (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [spc_pkg::SW-1:0] i_sum,
    output logic      [spc_pkg::LW-1:0] o_root
);
    import spc_pkg::*;

    logic [LW+1:0]   r_rem  [SQ_STAGES];
    logic [LW-1:0]   r_root [SQ_STAGES];
    logic [2*LW-1:0] r_val  [SQ_STAGES];

    genvar s;
    for (s = 0; s < SQ_STAGES; s++) begin : g_st
        logic [LW+1:0]   rem_in;
        logic [LW-1:0]   root_in;
        logic [2*LW-1:0] val_in;
        logic [LW+3:0]   cat;
        logic [LW+3:0]   trial;
        logic            ge;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = {{(2*LW-SW){1'b0}}, i_sum};
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
            assign val_in  = r_val[s-1];
        end

        assign cat   = {rem_in, val_in[2*LW-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = (cat >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= ge ? (LW+2)'(cat - trial) : cat[LW+1:0];
                r_root[s] <= {root_in[LW-2:0], ge};
                r_val[s]  <= {val_in[2*LW-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[SQ_STAGES-1];
endmodule
`default_nettype wire

FILE: rtl/spc_div.sv
`default_nettype none
// Pipelined restoring divider; quotient is known to fit QW bits.
module spc_div (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [spc_pkg::NW-1:0] i_num,
    input  wire logic [spc_pkg::LW-1:0] i_den,
    output logic      [spc_pkg::QW-1:0] o_quot
);
    import spc_pkg::*;

    logic [LW-1:0] r_rem [DIV_STAGES];
    logic [QW-1:0] r_low [DIV_STAGES];
    logic [QW-1:0] r_q   [DIV_STAGES];
    logic [LW-1:0] r_den [DIV_STAGES];

    genvar s;
    for (s = 0; s < DIV_STAGES; s++) begin : g_st
        logic [LW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] q_in;
        logic [LW-1:0] den_in;
        logic [LW:0]   cat;
        logic          ge;

        if (s == 0) begin : g_first
            assign rem_in = i_num[NW-1:QW];
            assign low_in = i_num[QW-1:0];
            assign q_in   = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign low_in = r_low[s-1];
            assign q_in   = r_q[s-1];
            assign den_in = r_den[s-1];
        end

        assign cat = {rem_in, low_in[QW-1]};
        assign ge  = (cat >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= ge ? LW'(cat - {1'b0, den_in}) : cat[LW-1:0];
                r_low[s] <= {low_in[QW-2:0], 1'b0};
                r_q[s]   <= {q_in[QW-2:0], ge};
                r_den[s] <= den_in;
            end
        end
    end

    assign o_quot = r_q[DIV_STAGES-1];
endmodule
`default_nettype wire

FILE: rtl/sphere_pair_contact.sv
`default_nettype none
// Channel   Dir  Beat
// i_pair    in   two centers + two radii
// o_contact out  two touch points + gap
// i_cfg_*   in   detect distance write
//
// One beat per cycle while the output is not stalled; 34 root stages,
// 31 divider stages, plus difference, multiply, sum, numerator, output.
// A stalled output freezes the whole pipeline; i_pair.ready follows it.
// Reset clears valid bits and sets the detect distance to 1.0.
module sphere_pair_contact (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    spc_pair_if.sink                i_pair,
    spc_contact_if.source           o_contact,
    input  wire logic               i_cfg_we,
    input  wire spc_pkg::t_rad      i_cfg_wdata
);
    import spc_pkg::*;

    logic          en;
    logic [LAT-1:0] r_vld;
    t_rad          r_detect;

    assign en           = !r_vld[LAT-1] || o_contact.ready;
    assign i_pair.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_detect <= RW'(65536);
        end else begin
            if (i_cfg_we)
                r_detect <= i_cfg_wdata;
            if (en)
                r_vld <= {r_vld[LAT-2:0], i_pair.valid};
        end
    end

    // stage 0: difference
    t_coord [2:0]        in_a, in_b;
    t_coord [2:0]        r0_a, r0_b;
    t_rad                r0_ra, r0_rb;
    logic   [2:0]        r0_neg;
    logic   [2:0][DW-1:0] r0_mag;
    logic   [2:0][DW-1:0] n0_d;

    assign in_a = {i_pair.center_a_z, i_pair.center_a_y, i_pair.center_a_x};
    assign in_b = {i_pair.center_b_z, i_pair.center_b_y, i_pair.center_b_x};

    always_comb begin
        for (int i = 0; i < 3; i++)
            n0_d[i] = {in_b[i][CW-1], in_b[i]} - {in_a[i][CW-1], in_a[i]};
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_a  <= in_a;
            r0_b  <= in_b;
            r0_ra <= i_pair.radius_a;
            r0_rb <= i_pair.radius_b;
            for (int i = 0; i < 3; i++) begin
                r0_neg[i] <= n0_d[i][DW-1];
                r0_mag[i] <= n0_d[i][DW-1] ? DW'(-n0_d[i]) : n0_d[i];
            end
        end
    end

    // stage 1: squares and radius products
    t_side                r1_side;
    logic [2:0][SW-1:0]   r1_sq;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_side.a   <= r0_a;
            r1_side.b   <= r0_b;
            r1_side.ra  <= r0_ra;
            r1_side.rb  <= r0_rb;
            r1_side.neg <= r0_neg;
            for (int i = 0; i < 3; i++) begin
                r1_sq[i]      <= r0_mag[i] * r0_mag[i];
                r1_side.pa[i] <= r0_ra * r0_mag[i];
                r1_side.pb[i] <= r0_rb * r0_mag[i];
            end
        end
    end

    // stage 2: sum of squares
    t_side          r2_side;
    logic [SW-1:0]  r2_sum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_side <= r1_side;
            r2_sum  <= r1_sq[0] + r1_sq[1] + r1_sq[2];
        end
    end

    // root, side data delayed alongside
    logic [LW-1:0] root;
    t_side         r_dly [SQ_STAGES];

    spc_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sum  (r2_sum),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= r2_side;
            for (int k = 1; k < SQ_STAGES; k++)
                r_dly[k] <= r_dly[k-1];
        end
    end

    // numerator stage: round-to-nearest bias, gap and clamp
    t_side                   sq_side;
    logic signed [LW:0]      n3_gap;
    logic [2:0][NW-1:0]      r3_na, r3_nb;
    logic [LW-1:0]           r3_len;
    t_tail                   r3_tail;

    assign sq_side = r_dly[SQ_STAGES-1];
    assign n3_gap  = $signed({1'b0, root}) - $signed({4'b0, sq_side.ra})
                   - $signed({4'b0, sq_side.rb});

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r3_na[i] <= {1'b0, sq_side.pa[i]} + NW'(root[LW-1:1]);
                r3_nb[i] <= {1'b0, sq_side.pb[i]} + NW'(root[LW-1:1]);
            end
            r3_len        <= root;
            r3_tail.a     <= sq_side.a;
            r3_tail.b     <= sq_side.b;
            r3_tail.neg   <= sq_side.neg;
            r3_tail.lzero <= (root == '0);
            r3_tail.gap   <= (n3_gap > $signed({4'b0, r_detect}))
                             ? $signed({2'b0, r_detect}) : n3_gap[GW-1:0];
        end
    end

    // dividers
    logic [2:0][QW-1:0] qa, qb;
    t_tail              r_dly2 [DIV_STAGES];

    genvar g;
    for (g = 0; g < 3; g++) begin : g_axis
        spc_div u_div_a (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r3_na[g]),
            .i_den  (r3_len),
            .o_quot (qa[g])
        );
        spc_div u_div_b (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r3_nb[g]),
            .i_den  (r3_len),
            .o_quot (qb[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly2[0] <= r3_tail;
            for (int k = 1; k < DIV_STAGES; k++)
                r_dly2[k] <= r_dly2[k-1];
        end
    end

    // output stage: signed offsets, saturating add
    t_tail                     tl;
    logic [2:0][QW+1:0]        off_a, off_b;
    t_coord [2:0]              n_ta, n_tb;
    t_coord [2:0]              r_ta, r_tb;
    t_gap                      r_gap;

    assign tl = r_dly2[DIV_STAGES-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (tl.lzero) begin
                off_a[i] = '0;
                off_b[i] = '0;
            end else begin
                off_a[i] = tl.neg[i] ? (QW+2)'(-{2'b00, qa[i]}) : {2'b00, qa[i]};
                off_b[i] = tl.neg[i] ? (QW+2)'(-{2'b00, qb[i]}) : {2'b00, qb[i]};
            end
            n_ta[i] = sat32($signed({{2{tl.a[i][CW-1]}}, tl.a[i]})
                            + $signed({off_a[i][QW+1], off_a[i]}));
            n_tb[i] = sat32($signed({{2{tl.b[i][CW-1]}}, tl.b[i]})
                            - $signed({off_b[i][QW+1], off_b[i]}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ta  <= n_ta;
            r_tb  <= n_tb;
            r_gap <= tl.gap;
        end
    end

    assign o_contact.valid     = r_vld[LAT-1];
    assign o_contact.touch_a_x = r_ta[0];
    assign o_contact.touch_a_y = r_ta[1];
    assign o_contact.touch_a_z = r_ta[2];
    assign o_contact.touch_b_x = r_tb[0];
    assign o_contact.touch_b_y = r_tb[1];
    assign o_contact.touch_b_z = r_tb[2];
    assign o_contact.gap       = r_gap;
endmodule
`default_nettype wire

FILE: rtl/spc_checker.sv
`default_nettype none
module spc_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_valid,
    input wire logic            i_in_ready,
    input wire logic            i_out_valid,
    input wire logic            i_out_ready,
    input wire spc_pkg::t_gap   i_gap
);
    import spc_pkg::*;

    // nothing comes out right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");

    // empty output slot means the pipeline moves
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // stall freezes input side too
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input taken during output stall");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output beat dropped while stalled");

    a_gap_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_gap >= -$signed(33'sh0FFFFFFFE)))
        else $error("gap below lower bound");
endmodule

bind sphere_pair_contact spc_checker u_spc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pair.valid),
    .i_in_ready  (i_pair.ready),
    .i_out_valid (o_contact.valid),
    .i_out_ready (o_contact.ready),
    .i_gap       (o_contact.gap)
);
`default_nettype wire

FILE: tb/sv/sphere_pair_contact_tb.sv
`timescale 1ns / 1ps

import spc_pkg::*;

typedef struct {
    t_coord a[3];
    t_coord b[3];
    t_rad   ra;
    t_rad   rb;
} t_sphere_pair;

// touch_a x/y/z, touch_b x/y/z, gap; coordinates in the low 32 bits
typedef logic [6:0][32:0] t_contact;

class contact_scoreboard;
    t_contact pending_contacts[$];
    t_rad     detect_dist;
    bit       failed;
    string    field_name[7] = '{"touch_a_x", "touch_a_y", "touch_a_z",
                                "touch_b_x", "touch_b_y", "touch_b_z", "gap"};

    function new();
        detect_dist = 31'd65536;
        failed      = 0;
    endfunction

    static function logic [31:0] clip32(logic signed [35:0] v);
        if (v > 36'sd2147483647)
            return 32'h7FFFFFFF;
        if (v < -36'sd2147483648)
            return 32'h80000000;
        return v[31:0];
    endfunction

    function t_contact predict_contact(t_sphere_pair p);
        logic signed [33:0] d[3];
        logic        [32:0] mag[3];
        logic        [65:0] sum_sq;
        logic        [67:0] sq;
        logic        [33:0] len;
        logic        [33:0] cand;
        logic        [65:0] num;
        logic        [32:0] qa, qb;
        logic signed [35:0] off_a, off_b, va, vb, g;
        t_contact           res;
        sum_sq = '0;
        for (int i = 0; i < 3; i++) begin
            d[i]   = {{2{p.b[i][31]}}, p.b[i]} - {{2{p.a[i][31]}}, p.a[i]};
            mag[i] = d[i][33] ? 33'(-d[i]) : d[i][32:0];
            sum_sq = sum_sq + 66'(mag[i]) * 66'(mag[i]);
        end
        len = '0;
        for (int k = 33; k >= 0; k--) begin
            cand = len | (34'd1 << k);
            sq   = 68'(cand) * 68'(cand);
            if (sq <= 68'(sum_sq))
                len = cand;
        end
        for (int i = 0; i < 3; i++) begin
            qa = '0;
            qb = '0;
            if (len != 0) begin
                num = 66'(p.ra) * 66'(mag[i]) + 66'(len >> 1);
                qa  = 33'(num / 66'(len));
                num = 66'(p.rb) * 66'(mag[i]) + 66'(len >> 1);
                qb  = 33'(num / 66'(len));
            end
            off_a = $signed({3'b000, qa});
            off_b = $signed({3'b000, qb});
            if (d[i][33]) begin
                off_a = -off_a;
                off_b = -off_b;
            end
            va = $signed({{4{p.a[i][31]}}, p.a[i]}) + off_a;
            vb = $signed({{4{p.b[i][31]}}, p.b[i]}) - off_b;
            res[i]     = {1'b0, clip32(va)};
            res[3 + i] = {1'b0, clip32(vb)};
        end
        g = $signed({2'b00, len}) - $signed({5'b0, p.ra}) - $signed({5'b0, p.rb});
        if (g > $signed({5'b0, detect_dist}))
            g = $signed({5'b0, detect_dist});
        res[6] = g[32:0];
        return res;
    endfunction

    function void note_pair(t_sphere_pair p);
        pending_contacts = {pending_contacts, predict_contact(p)};
    endfunction

    function void check_contact(t_contact got);
        t_contact want;
        if (pending_contacts.size() == 0) begin
            $display("%0t: unexpected contact beat %h", $time, got);
            failed = 1;
            return;
        end
        want = pending_contacts.pop_front();
        for (int i = 0; i < 7; i++)
            if (want[i] !== got[i]) begin
                $display("%0t: %s expected %h actual %h", $time, field_name[i],
                         want[i], got[i]);
                failed = 1;
            end
    endfunction
endclass

module sphere_pair_contact_tb;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_rad i_cfg_wdata;

    spc_pair_if    pair_bus();
    spc_contact_if contact_bus();

    sphere_pair_contact uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pair      (pair_bus),
        .o_contact   (contact_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    contact_scoreboard sb = new();

    int unsigned cycle_cnt;
    int unsigned rx_hold;       // receiver hold-off, in cycles
    bit          tx_calm;       // sender stretch with no gaps

    localparam int unsigned CYCLE_LIMIT = 400000;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        pair_bus.valid      = 1'b0;
        pair_bus.center_a_x = '0;
        pair_bus.center_a_y = '0;
        pair_bus.center_a_z = '0;
        pair_bus.radius_a   = '0;
        pair_bus.center_b_x = '0;
        pair_bus.center_b_y = '0;
        pair_bus.center_b_z = '0;
        pair_bus.radius_b   = '0;
        contact_bus.ready   = 1'b0;
        cycle_cnt           = 0;
        rx_hold             = 0;
        tx_calm             = 0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls, with a recurring quiet window of no stalls
    always @(negedge i_clk) begin
        if (!i_rst_n)
            contact_bus.ready <= 1'b0;
        else if (rx_hold != 0) begin
            contact_bus.ready <= 1'b0;
            rx_hold           <= rx_hold - 1;
        end else if ((cycle_cnt % 3000) < 500)
            contact_bus.ready <= 1'b1;
        else
            contact_bus.ready <= ($urandom_range(99) >= 25);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && contact_bus.valid && contact_bus.ready)
            sb.check_contact({1'b0, contact_bus.gap[32], contact_bus.gap[31:0]} == 0 ?
                             {contact_bus.gap, 1'b0, contact_bus.touch_b_z,
                              1'b0, contact_bus.touch_b_y, 1'b0, contact_bus.touch_b_x,
                              1'b0, contact_bus.touch_a_z, 1'b0, contact_bus.touch_a_y,
                              1'b0, contact_bus.touch_a_x} :
                             {contact_bus.gap, 1'b0, contact_bus.touch_b_z,
                              1'b0, contact_bus.touch_b_y, 1'b0, contact_bus.touch_b_x,
                              1'b0, contact_bus.touch_a_z, 1'b0, contact_bus.touch_a_y,
                              1'b0, contact_bus.touch_a_x});
    end

    task automatic send_pair(t_sphere_pair p);
        int unsigned idle;
        idle = 0;
        if (!tx_calm && $urandom_range(99) < 25)
            idle = $urandom_range(1, 4);
        if (idle != 0) begin
            @(negedge i_clk);
            pair_bus.valid = 1'b0;
            repeat (idle - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        pair_bus.valid      = 1'b1;
        pair_bus.center_a_x = p.a[0];
        pair_bus.center_a_y = p.a[1];
        pair_bus.center_a_z = p.a[2];
        pair_bus.radius_a   = p.ra;
        pair_bus.center_b_x = p.b[0];
        pair_bus.center_b_y = p.b[1];
        pair_bus.center_b_z = p.b[2];
        pair_bus.radius_b   = p.rb;
        do
            @(posedge i_clk);
        while (!pair_bus.ready);
        sb.note_pair(p);
    endtask

    task automatic drain_and_settle();
        @(negedge i_clk);
        pair_bus.valid = 1'b0;
        while (sb.pending_contacts.size() != 0)
            @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
    endtask

    task automatic write_detect(t_rad val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.detect_dist = val;
    endtask

    function automatic t_sphere_pair make_pair(t_coord ax, t_coord ay, t_coord az, t_rad ra,
                                               t_coord bx, t_coord by, t_coord bz, t_rad rb);
        t_sphere_pair p;
        p.a[0] = ax; p.a[1] = ay; p.a[2] = az; p.ra = ra;
        p.b[0] = bx; p.b[1] = by; p.b[2] = bz; p.rb = rb;
        return p;
    endfunction

    function automatic t_rad rand_radius();
        case ($urandom_range(3))
            0:       return t_rad'($urandom);
            1:       return t_rad'($urandom_range(0, 3 << 16));
            2:       return $urandom_range(1) ? '0 : '1;
            default: return t_rad'($urandom_range(0, 1 << 20));
        endcase
    endfunction

    function automatic t_sphere_pair rand_pair();
        t_sphere_pair p;
        int unsigned  mode;
        mode = $urandom_range(9);
        p.ra = rand_radius();
        p.rb = rand_radius();
        for (int i = 0; i < 3; i++) begin
            p.a[i] = t_coord'($urandom);
            case (mode)
                0, 1:    p.b[i] = t_coord'($urandom);
                6:       p.b[i] = p.a[i];   // coincident centers
                7:       p.b[i] = p.a[i] + t_coord'($urandom_range(0, 1 << 22)) - (1 << 21);
                8:       begin
                    p.a[i] = $urandom_range(1) ? 32'h80000000 : 32'h7FFFFFFF;
                    p.b[i] = $urandom_range(1) ? 32'h80000000 : 32'h7FFFFFFF;
                end
                default: p.b[i] = p.a[i] + t_coord'($urandom_range(0, 1 << 18)) - (1 << 17);
            endcase
        end
        return p;
    endfunction

    initial begin
        t_rad         settings[4];
        t_sphere_pair p;
        settings[0] = 31'd65536;
        settings[1] = '0;
        settings[2] = '1;
        settings[3] = t_rad'($urandom);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, coincident centers, far and overlapping spheres
        send_pair(make_pair('0, '0, '0, '0, '0, '0, '0, '0));
        send_pair(make_pair(5 << 16, -7 << 16, 3, 31'd65536,
                            5 << 16, -7 << 16, 3, 31'd131072));
        send_pair(make_pair(32'h80000000, 32'h80000000, 32'h80000000, '1,
                            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, '1));
        send_pair(make_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, '1,
                            32'h80000000, 32'h80000000, 32'h80000000, '1));
        send_pair(make_pair(32'h7FFFFFFF, 0, 0, '1, 32'h7FFFFFFF - 1, 0, 0, '1));
        send_pair(make_pair(32'h80000000, 0, 0, '1, 32'h80000000 + 1, 0, 0, '1));
        send_pair(make_pair(0, 0, 0, 31'd65536, 3 << 16, 4 << 16, 0, 31'd65536));
        send_pair(make_pair(0, 0, 0, 31'd65536, 100 << 16, 0, 0, 31'd65536));
        send_pair(make_pair(0, 0, 0, 31'd196608, 1 << 16, 1 << 16, 1 << 16, 31'd196608));
        send_pair(make_pair(0, 0, 0, 31'd1, 1, 1, 0, 31'd1));
        send_pair(make_pair(0, 0, 0, '1, 0, 0, 1, '0));
        send_pair(make_pair(-1, -1, -1, 31'd7, 1, 1, 1, 31'd9));
        send_pair(make_pair(32'h55555555, 32'hAAAAAAAA, 0, 31'h2AAAAAAA,
                            32'hAAAAAAAA, 32'h55555555, -1, 31'h55555555));
        send_pair(make_pair(32'h80000000, 32'h80000000, 32'h80000000, '0,
                            32'h80000000, 32'h80000000, 32'h80000000, '1));
        drain_and_settle();

        for (int ph = 0; ph < 4; ph++) begin
            write_detect(settings[ph]);
            for (int n = 0; n < 210; n++) begin
                tx_calm = (n >= 40 && n < 90);
                // long output hold-off while the sender keeps streaming
                if (ph == 1 && n == 30)
                    rx_hold = 300;
                p = rand_pair();
                send_pair(p);
            end
            tx_calm = 0;
            drain_and_settle();
        end
        write_detect(31'd65536);

        if (!sb.failed)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sphere_pair_contact.f
rtl/spc_pkg.sv
rtl/spc_pair_if.sv
rtl/spc_contact_if.sv
rtl/spc_sqrt.sv
rtl/spc_div.sv
rtl/sphere_pair_contact.sv
rtl/spc_checker.sv
tb/sv/sphere_pair_contact_tb.sv
